// ----- sv/assert_macros.svh -----
// Assertion macros shared by the turmite step engine RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// The condition must never hold.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_NEVER(label, cond, msg)
`define ASSERT_IMPLIES(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- sv/tmt_pkg.sv -----
// Shared constants, types and helper functions of the turmite step engine.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package tmt_pkg;

  localparam int GRID_SIZE  = 256;
  localparam int NUM_STATES = 256;
  localparam int COORD_W    = $clog2(GRID_SIZE);
  localparam int STATE_AW   = $clog2(NUM_STATES);
  // Signed width that holds a coordinate plus or minus an 8-bit move.
  localparam int SUM_W      = ((COORD_W > 8) ? COORD_W : 8) + 2;

  typedef logic [COORD_W-1:0]          coord_t;
  typedef logic signed [SUM_W-1:0]     sum_t;
  typedef logic [GRID_SIZE-1:0]        row_t;
  typedef logic [STATE_AW-1:0]         saddr_t;

  localparam coord_t ROW_LAST    = COORD_W'(GRID_SIZE - 1);
  localparam sum_t   COORD_MAX_S = SUM_W'(GRID_SIZE - 1);

  // Commands carried by an input request.
  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_STEP    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_START_X       = 3'd0;
  localparam logic [2:0] CFG_START_Y       = 3'd1;
  localparam logic [2:0] CFG_START_HEADING = 3'd2;
  localparam logic [2:0] CFG_START_STATE   = 3'd3;
  localparam logic [2:0] CFG_MOVE_FIRST    = 3'd4;

  // Directions in the low two heading bits.
  localparam logic [1:0] DIR_PX = 2'd0;
  localparam logic [1:0] DIR_NY = 2'd1;
  localparam logic [1:0] DIR_NX = 2'd2;
  localparam logic [1:0] DIR_PY = 2'd3;

  // Register values after reset.
  localparam logic [7:0] RST_START_X       = 8'd128;
  localparam logic [7:0] RST_START_Y       = 8'd128;
  localparam logic [7:0] RST_START_HEADING = 8'd64;
  localparam logic [7:0] RST_START_STATE   = 8'd0;
  localparam logic       RST_MOVE_FIRST    = 1'b0;

  typedef struct packed {
    logic [7:0] turn;
    logic [7:0] move;
    logic       toggle;
    logic [7:0] next;
  } action_t;

  typedef struct packed {
    action_t act_clr;
    action_t act_set;
  } rule_t;

  typedef struct packed {
    logic   clear_start;
    logic   rd_en;
    logic   tog_en;
    coord_t row;
    coord_t col;
  } grid_req_t;

  typedef struct packed {
    logic   en;
    saddr_t addr;
    rule_t  data;
  } rule_wr_t;

  typedef struct packed {
    logic       en;
    logic [7:0] state;
  } rule_rd_t;

  function automatic logic in_table(logic [7:0] v);
    return (32'(v) < NUM_STATES);
  endfunction

  function automatic saddr_t state_addr(logic [7:0] v);
    return STATE_AW'(v);
  endfunction

  function automatic coord_t start_coord(logic [7:0] v);
    coord_t c;
    if (32'(v) >= GRID_SIZE) begin
      c = '0;
    end else begin
      c = COORD_W'(v);
    end
    return c;
  endfunction

  function automatic sum_t ext_coord(coord_t c);
    return sum_t'({{(SUM_W-COORD_W){1'b0}}, c});
  endfunction

  function automatic sum_t ext_move(logic [7:0] d);
    return sum_t'({{(SUM_W-8){d[7]}}, d});
  endfunction

  // Leaving the grid jumps to the opposite edge; this is not a modulo.
  function automatic coord_t wrap_coord(sum_t s);
    coord_t c;
    if (s > COORD_MAX_S) begin
      c = '0;
    end else if (s[SUM_W-1]) begin
      c = ROW_LAST;
    end else begin
      c = s[COORD_W-1:0];
    end
    return c;
  endfunction

  function automatic logic [7:0] to_byte(coord_t c);
    return 8'(c);
  endfunction

  function automatic row_t bit_mask(coord_t c);
    return row_t'(1) << c;
  endfunction

endpackage

`default_nettype wire

// ----- sv/tmt_grid_store.sv -----
// Grid bit memory, one row per word, with read-modify-write toggling and a
// row-per-cycle clearing pass. Depends on tmt_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tmt_grid_store (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire tmt_pkg::grid_req_t   req,
  output logic                      cell_bit,
  output logic                      busy
);

  tmt_pkg::row_t   mem [tmt_pkg::GRID_SIZE];
  tmt_pkg::row_t   rdata_r;
  tmt_pkg::coord_t clr_cnt_r;
  logic            busy_r;

  logic            wr_en;
  tmt_pkg::coord_t wr_addr;
  tmt_pkg::row_t   wr_data;

  // A toggle writes back the row fetched by the previous read.
  assign wr_en   = busy_r | req.tog_en;
  assign wr_addr = busy_r ? clr_cnt_r : req.row;
  assign wr_data = busy_r ? '0 : (rdata_r ^ tmt_pkg::bit_mask(req.col));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (req.rd_en) begin
      rdata_r <= mem[req.row];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_cnt_r <= '0;
    end else if (req.clear_start) begin
      busy_r    <= 1'b1;
      clr_cnt_r <= '0;
    end else if (busy_r) begin
      if (clr_cnt_r == tmt_pkg::ROW_LAST) begin
        busy_r <= 1'b0;
      end
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign cell_bit = rdata_r[req.col];
  assign busy     = busy_r;

  `ASSERT_NEVER(a_clr_overlap, busy_r && (req.rd_en || req.tog_en), "grid access during clear")
  `ASSERT_IMPLIES(a_clr_end, $fell(busy_r), $past(clr_cnt_r) == tmt_pkg::ROW_LAST, "clear cut short")
  `ASSERT_NEXT(a_clr_go, req.clear_start, busy_r && (clr_cnt_r == '0), "clear did not start")

endmodule

`default_nettype wire

// ----- sv/tmt_rule_store.sv -----
// Rule table memory with a registered read and action selection by the
// cell value. Depends on tmt_pkg.
`default_nettype none

module tmt_rule_store (
  input  wire logic                clk,
  input  wire tmt_pkg::rule_wr_t   wr,
  input  wire tmt_pkg::rule_rd_t   rd,
  input  wire logic                cell_bit,
  output tmt_pkg::action_t         act
);

  tmt_pkg::rule_t mem [tmt_pkg::NUM_STATES];
  tmt_pkg::rule_t rdata_r;
  logic           in_range_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rdata_r    <= mem[tmt_pkg::state_addr(rd.state)];
      in_range_r <= tmt_pkg::in_table(rd.state);
    end
  end

  // A state outside the table behaves as an all-zero action.
  always_comb begin
    if (!in_range_r) begin
      act = '0;
    end else if (cell_bit) begin
      act = rdata_r.act_set;
    end else begin
      act = rdata_r.act_clr;
    end
  end

endmodule

`default_nettype wire

// ----- sv/tmt_step_ctrl.sv -----
// Sequencer of the turmite: ant registers, configuration registers, move and
// turn arithmetic, and the result register. Depends on tmt_pkg and
// assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tmt_step_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          in_command,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [7:0]          cfg_data,
  output tmt_pkg::grid_req_t       grid_req,
  input  wire logic                cell_bit,
  input  wire logic                clear_busy,
  output tmt_pkg::rule_rd_t        rule_rd,
  input  wire tmt_pkg::action_t    act,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [7:0]               out_pos_x,
  output logic [7:0]               out_pos_y,
  output logic [7:0]               out_heading,
  output logic [7:0]               out_ant_state,
  output logic                     out_cell_seen,
  output logic                     out_cell_flipped
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_DONE  = 3'd3;
  localparam logic [2:0] S_CLEAR = 3'd4;

  logic [2:0]      st_r, st_nxt;
  logic            clr_report_r, clr_report_nxt;
  tmt_pkg::coord_t ant_x_r, ant_x_nxt, ant_y_r, ant_y_nxt;
  logic [7:0]      ant_head_r, ant_head_nxt, ant_state_r, ant_state_nxt;
  logic            seen_r, seen_nxt, flipped_r, flipped_nxt;
  logic [7:0]      start_x_r, start_x_nxt, start_y_r, start_y_nxt;
  logic [7:0]      start_head_r, start_head_nxt, start_state_r, start_state_nxt;
  logic            move_first_r, move_first_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_pos_x_r, out_pos_y_r, out_heading_r, out_ant_state_r;
  logic            out_seen_r, out_flipped_r;

  logic            out_free;
  logic            out_load;
  logic [7:0]      head_turn;
  logic [1:0]      dir;
  tmt_pkg::sum_t   x_ext, y_ext, d_ext, x_sum, y_sum;
  tmt_pkg::coord_t x_new, y_new;

  assign in_ready  = (st_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  // Move and turn for the step in flight; the move uses the heading before
  // the turn in move-first mode and the turned heading otherwise.
  always_comb begin
    head_turn = ant_head_r + act.turn;
    dir       = move_first_r ? ant_head_r[1:0] : head_turn[1:0];
    x_ext     = tmt_pkg::ext_coord(ant_x_r);
    y_ext     = tmt_pkg::ext_coord(ant_y_r);
    d_ext     = tmt_pkg::ext_move(act.move);
    x_sum     = x_ext;
    y_sum     = y_ext;
    case (dir)
      tmt_pkg::DIR_PX: x_sum = x_ext + d_ext;
      tmt_pkg::DIR_NY: y_sum = y_ext - d_ext;
      tmt_pkg::DIR_NX: x_sum = x_ext - d_ext;
      default:         y_sum = y_ext + d_ext;
    endcase
    x_new = tmt_pkg::wrap_coord(x_sum);
    y_new = tmt_pkg::wrap_coord(y_sum);
  end

  always_comb begin
    st_nxt          = st_r;
    clr_report_nxt  = clr_report_r;
    ant_x_nxt       = ant_x_r;
    ant_y_nxt       = ant_y_r;
    ant_head_nxt    = ant_head_r;
    ant_state_nxt   = ant_state_r;
    seen_nxt        = seen_r;
    flipped_nxt     = flipped_r;
    start_x_nxt     = start_x_r;
    start_y_nxt     = start_y_r;
    start_head_nxt  = start_head_r;
    start_state_nxt = start_state_r;
    move_first_nxt  = move_first_r;
    out_load        = 1'b0;

    grid_req        = '0;
    grid_req.row    = ant_y_r;
    grid_req.col    = ant_x_r;
    rule_rd         = '0;
    rule_rd.state   = ant_state_r;

    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_command)
            tmt_pkg::CMD_STEP: begin
              grid_req.rd_en = 1'b1;
              rule_rd.en     = 1'b1;
              st_nxt         = S_READ;
            end
            tmt_pkg::CMD_RESTART: begin
              grid_req.clear_start = 1'b1;
              ant_x_nxt      = tmt_pkg::start_coord(start_x_r);
              ant_y_nxt      = tmt_pkg::start_coord(start_y_r);
              ant_head_nxt   = start_head_r;
              ant_state_nxt  = start_state_r;
              seen_nxt       = 1'b0;
              flipped_nxt    = 1'b0;
              clr_report_nxt = 1'b1;
              st_nxt         = S_CLEAR;
            end
            default: begin
              seen_nxt    = 1'b0;
              flipped_nxt = 1'b0;
              st_nxt      = S_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        ant_x_nxt      = x_new;
        ant_y_nxt      = y_new;
        ant_head_nxt   = head_turn;
        ant_state_nxt  = act.next;
        seen_nxt       = cell_bit;
        flipped_nxt    = act.toggle;
        // Fetch the row at the new position for the toggle.
        grid_req.rd_en = 1'b1;
        grid_req.row   = y_new;
        st_nxt         = S_WRITE;
      end
      S_WRITE: begin
        grid_req.tog_en = flipped_r;
        out_load        = out_free;
        st_nxt          = out_free ? S_IDLE : S_DONE;
      end
      S_DONE: begin
        out_load = out_free;
        if (out_free) begin
          st_nxt = S_IDLE;
        end
      end
      S_CLEAR: begin
        if (!clear_busy) begin
          st_nxt = clr_report_r ? S_DONE : S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase

    if (cfg_valid) begin
      case (cfg_index)
        tmt_pkg::CFG_START_X:       start_x_nxt     = cfg_data;
        tmt_pkg::CFG_START_Y:       start_y_nxt     = cfg_data;
        tmt_pkg::CFG_START_HEADING: start_head_nxt  = cfg_data;
        tmt_pkg::CFG_START_STATE:   start_state_nxt = cfg_data;
        tmt_pkg::CFG_MOVE_FIRST:    move_first_nxt  = cfg_data[0];
        default: ;
      endcase
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= S_CLEAR;
      clr_report_r  <= 1'b0;
      ant_x_r       <= tmt_pkg::start_coord(tmt_pkg::RST_START_X);
      ant_y_r       <= tmt_pkg::start_coord(tmt_pkg::RST_START_Y);
      ant_head_r    <= tmt_pkg::RST_START_HEADING;
      ant_state_r   <= tmt_pkg::RST_START_STATE;
      seen_r        <= 1'b0;
      flipped_r     <= 1'b0;
      start_x_r     <= tmt_pkg::RST_START_X;
      start_y_r     <= tmt_pkg::RST_START_Y;
      start_head_r  <= tmt_pkg::RST_START_HEADING;
      start_state_r <= tmt_pkg::RST_START_STATE;
      move_first_r  <= tmt_pkg::RST_MOVE_FIRST;
      out_valid_r   <= 1'b0;
    end else begin
      st_r          <= st_nxt;
      clr_report_r  <= clr_report_nxt;
      ant_x_r       <= ant_x_nxt;
      ant_y_r       <= ant_y_nxt;
      ant_head_r    <= ant_head_nxt;
      ant_state_r   <= ant_state_nxt;
      seen_r        <= seen_nxt;
      flipped_r     <= flipped_nxt;
      start_x_r     <= start_x_nxt;
      start_y_r     <= start_y_nxt;
      start_head_r  <= start_head_nxt;
      start_state_r <= start_state_nxt;
      move_first_r  <= move_first_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pos_x_r     <= tmt_pkg::to_byte(ant_x_r);
      out_pos_y_r     <= tmt_pkg::to_byte(ant_y_r);
      out_heading_r   <= ant_head_r;
      out_ant_state_r <= ant_state_r;
      out_seen_r      <= seen_r;
      out_flipped_r   <= flipped_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pos_x        = out_pos_x_r;
  assign out_pos_y        = out_pos_y_r;
  assign out_heading      = out_heading_r;
  assign out_ant_state    = out_ant_state_r;
  assign out_cell_seen    = out_seen_r;
  assign out_cell_flipped = out_flipped_r;

  `ASSERT_IMPLIES(a_busy_clear, clear_busy, st_r == S_CLEAR, "grid clear outside clear state")
  `ASSERT_NEXT(a_read_next, st_r == S_READ, st_r == S_WRITE, "step read not followed by write")
  `ASSERT_NEXT(a_step_go, in_valid && in_ready && (in_command == tmt_pkg::CMD_STEP), st_r == S_READ, "step request not started")

endmodule

`default_nettype wire

// ----- sv/turmite_step_engine_top.sv -----
// Turmite step engine: a step request reads the grid row and rule entry,
// then does the move and turn, then writes back the toggled row; the result
// register is loaded in the write-back state, or later while the output
// stalls. Rule writes and ignored commands give a result too. A restart waits
// for the row-per-cycle grid clear. After reset the grid is cleared row by
// row; in_ready rises when the clear is done.
`default_nettype none

module turmite_step_engine_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_command,
  input  wire logic [7:0]         in_entry_index,
  input  wire logic signed [7:0]  in_clear_turn,
  input  wire logic signed [7:0]  in_clear_move,
  input  wire logic               in_clear_toggle,
  input  wire logic [7:0]         in_clear_next,
  input  wire logic signed [7:0]  in_set_turn,
  input  wire logic signed [7:0]  in_set_move,
  input  wire logic               in_set_toggle,
  input  wire logic [7:0]         in_set_next,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [7:0]         cfg_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_pos_x,
  output logic [7:0]              out_pos_y,
  output logic [7:0]              out_heading,
  output logic [7:0]              out_ant_state,
  output logic                    out_cell_seen,
  output logic                    out_cell_flipped
);

  tmt_pkg::grid_req_t grid_req;
  tmt_pkg::rule_wr_t  rule_wr;
  tmt_pkg::rule_rd_t  rule_rd;
  tmt_pkg::action_t   act;
  logic               cell_bit;
  logic               clear_busy;

  // Rule writes go straight to the table when the request is taken.
  always_comb begin
    rule_wr.en = in_valid && in_ready && (in_command == tmt_pkg::CMD_WRITE)
                 && tmt_pkg::in_table(in_entry_index);
    rule_wr.addr                = tmt_pkg::state_addr(in_entry_index);
    rule_wr.data.act_clr.turn   = in_clear_turn;
    rule_wr.data.act_clr.move   = in_clear_move;
    rule_wr.data.act_clr.toggle = in_clear_toggle;
    rule_wr.data.act_clr.next   = in_clear_next;
    rule_wr.data.act_set.turn   = in_set_turn;
    rule_wr.data.act_set.move   = in_set_move;
    rule_wr.data.act_set.toggle = in_set_toggle;
    rule_wr.data.act_set.next   = in_set_next;
  end

  tmt_grid_store u_grid (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (grid_req),
    .cell_bit (cell_bit),
    .busy     (clear_busy)
  );

  tmt_rule_store u_rule (
    .clk      (clk),
    .wr       (rule_wr),
    .rd       (rule_rd),
    .cell_bit (cell_bit),
    .act      (act)
  );

  tmt_step_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .grid_req         (grid_req),
    .cell_bit         (cell_bit),
    .clear_busy       (clear_busy),
    .rule_rd          (rule_rd),
    .act              (act),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_heading      (out_heading),
    .out_ant_state    (out_ant_state),
    .out_cell_seen    (out_cell_seen),
    .out_cell_flipped (out_cell_flipped)
  );

endmodule

`default_nettype wire
